/* design/utd_pkg.sv */
package utd_pkg;

  // Depth of the queue between the decoding front end and the output back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int SCALAR_W = 21;

  // Kinds of work that the front end hands to the back end.
  localparam logic [1:0] JOB_UNIT  = 2'd0;  // one code unit
  localparam logic [1:0] JOB_PAIR  = 2'd1;  // surrogate pair
  localparam logic [1:0] JOB_ERROR = 2'd2;  // invalid string

  // Byte class boundaries.
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] CONT_MIN  = 8'h80;

  localparam logic [SCALAR_W-1:0] SURR_MIN   = 21'h00D800;
  localparam logic [SCALAR_W-1:0] SURR_MAX   = 21'h00DFFF;
  localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10FFFF;
  localparam logic [SCALAR_W-1:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [SCALAR_W-1:0] PLANE1     = 21'h010000;
  localparam logic [15:0]         HIGH_BASE  = 16'hD800;
  localparam logic [15:0]         LOW_BASE   = 16'hDC00;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SCALAR_W-1:0] scalar;
    logic                eos;
  } job_t;

endpackage

/* design/utd_front.sv */
module utd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          end_of_string,
  output logic          push,
  output utd_pkg::job_t job
);
  import utd_pkg::*;

  logic [SCALAR_W-1:0] partial_scalar, partial_scalar_next;
  logic [1:0]          bytes_owed, bytes_owed_next;
  logic                discarding, discarding_next;

  logic [SCALAR_W-1:0] gathered;
  logic [1:0]          owed_after;
  logic                fault;
  logic                emit;

  always_comb begin
    gathered   = partial_scalar;
    owed_after = bytes_owed;
    fault      = 1'b0;
    emit       = 1'b0;

    if (bytes_owed == 2'd0) begin
      if (data_byte <= ASCII_MAX) begin
        gathered = {13'd0, data_byte};
      end else if (data_byte <= CONT_MAX) begin
        fault = 1'b1;
      end else if (data_byte <= LEAD2_MAX) begin
        gathered   = {16'd0, data_byte[4:0]};
        owed_after = 2'd1;
      end else if (data_byte <= LEAD3_MAX) begin
        gathered   = {17'd0, data_byte[3:0]};
        owed_after = 2'd2;
      end else if (data_byte <= LEAD4_MAX) begin
        gathered   = {18'd0, data_byte[2:0]};
        owed_after = 2'd3;
      end else begin
        fault = 1'b1;
      end
    end else begin
      if (data_byte < CONT_MIN || data_byte > CONT_MAX) begin
        fault = 1'b1;
      end else begin
        gathered   = {partial_scalar[SCALAR_W-7:0], data_byte[5:0]};
        owed_after = bytes_owed - 2'd1;
      end
    end

    if (!fault) begin
      if (owed_after != 2'd0) begin
        fault = end_of_string;
      end else if ((gathered >= SURR_MIN && gathered <= SURR_MAX) || gathered > SCALAR_MAX) begin
        fault = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end
  end

  always_comb begin
    partial_scalar_next = partial_scalar;
    bytes_owed_next     = bytes_owed;
    discarding_next     = discarding;
    push                = 1'b0;
    job.kind            = JOB_UNIT;
    job.scalar          = gathered;
    job.eos             = end_of_string;

    if (accept) begin
      if (discarding) begin
        if (end_of_string) begin
          discarding_next = 1'b0;
        end
      end else if (fault) begin
        push                = 1'b1;
        job.kind            = JOB_ERROR;
        partial_scalar_next = '0;
        bytes_owed_next     = 2'd0;
        discarding_next     = !end_of_string;
      end else if (emit) begin
        push                = 1'b1;
        job.kind            = (gathered > BMP_MAX) ? JOB_PAIR : JOB_UNIT;
        partial_scalar_next = '0;
        bytes_owed_next     = 2'd0;
      end else begin
        partial_scalar_next = gathered;
        bytes_owed_next     = owed_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_scalar <= '0;
      bytes_owed     <= 2'd0;
      discarding     <= 1'b0;
    end else begin
      partial_scalar <= partial_scalar_next;
      bytes_owed     <= bytes_owed_next;
      discarding     <= discarding_next;
    end
  end

endmodule

/* design/utd_queue.sv */
module utd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  utd_pkg::job_t wdata,
  input  logic          pop,
  output utd_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);
  import utd_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/utd_back.sv */
module utd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  utd_pkg::job_t head,
  output logic          pop,
  output logic          unit_valid,
  input  logic          unit_stall,
  output logic [15:0]   code_unit,
  output logic          is_error,
  output logic          run_last,
  output logic          string_done
);
  import utd_pkg::*;

  logic                second_half;
  logic                load;
  logic [SCALAR_W-1:0] offset;
  logic [15:0]         high_unit;
  logic [15:0]         low_unit;

  assign load      = !empty && (!unit_valid || !unit_stall);
  assign offset    = head.scalar - PLANE1;
  assign high_unit = HIGH_BASE + {6'd0, offset[19:10]};
  assign low_unit  = LOW_BASE + {6'd0, offset[9:0]};
  assign pop       = load && !(head.kind == JOB_PAIR && !second_half);

  always_ff @(posedge clk) begin
    if (load) begin
      case (head.kind)
        JOB_PAIR: begin
          code_unit   <= second_half ? low_unit : high_unit;
          is_error    <= 1'b0;
          run_last    <= second_half;
          string_done <= second_half && head.eos;
        end
        JOB_ERROR: begin
          code_unit   <= '0;
          is_error    <= 1'b1;
          run_last    <= 1'b1;
          string_done <= head.eos;
        end
        default: begin
          code_unit   <= head.scalar[15:0];
          is_error    <= 1'b0;
          run_last    <= 1'b1;
          string_done <= head.eos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid  <= 1'b0;
      second_half <= 1'b0;
    end else begin
      if (load) begin
        unit_valid <= 1'b1;
      end else if (!unit_stall) begin
        unit_valid <= 1'b0;
      end
      if (load && head.kind == JOB_PAIR) begin
        second_half <= !second_half;
      end
    end
  end

endmodule

/* design/utf8_to_utf16_stream_decoder.sv */
// UTF-8 to UTF-16 stream decoder. Bytes of a UTF-8 string arrive one per beat on the byte
// channel, the last byte of each string marked by end_of_string; UTF-16 code units leave one
// per beat on the unit channel. A completed scalar up to 0xFFFF gives one unit, a larger one a
// surrogate pair (high unit first, run_last set only on the low unit). The first fault in a
// string (stray or bad continuation, lead above 0xF7, truncation at the end mark, a surrogate
// value or one above 0x10FFFF) gives a single beat with is_error set and code_unit zero, and
// every further byte of that string is dropped up to and including its end byte. Overlong
// forms are accepted. string_done marks the last beat caused by an end byte. The block takes
// one byte per cycle while the queue is not full: the front end decodes a byte in the
// cycle it is accepted and posts at most one job to a four-entry queue, and the back end
// drains the queue into an output register at one beat per cycle while unit_stall is low,
// a surrogate pair giving two beats. Since a pair needs four input bytes, the output side
// keeps up with a full-rate input stream. Jobs pass the queue, then the output register.
module utf8_to_utf16_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        unit_valid,
  input  logic        unit_stall,
  output logic [15:0] code_unit,
  output logic        is_error,
  output logic        run_last,
  output logic        string_done
);
  import utd_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t new_job;
  job_t head_job;

  // The front end holds off only when the queue has no room for a job it might post.
  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  // Decoding state machine: partial scalar, bytes still owed and the drop flag.
  utd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .job           (new_job)
  );

  // Short queue that decouples decoding from the output handshake.
  utd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (new_job),
    .pop   (pop),
    .rdata (head_job),
    .full  (full),
    .empty (empty)
  );

  // Output side: turns each job into one or two beats in a registered stage.
  utd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .head        (head_job),
    .pop         (pop),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .code_unit   (code_unit),
    .is_error    (is_error),
    .run_last    (run_last),
    .string_done (string_done)
  );

endmodule

/* design/utd_checker.sv */
module utd_checker (
  input logic        clk,
  input logic        rst,
  input logic        unit_valid,
  input logic        unit_stall,
  input logic [15:0] code_unit,
  input logic        is_error,
  input logic        run_last,
  input logic        string_done
);

  // A held beat must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_stall |=> unit_valid && $stable(code_unit) && $stable(is_error)
      && $stable(run_last) && $stable(string_done))
    else $error("unit beat changed while stalled");

  // An error beat is the only beat of its byte and carries no unit.
  a_error: assert property (@(posedge clk) disable iff (rst)
    unit_valid && is_error |-> run_last && code_unit == 16'h0000)
    else $error("malformed error beat");

  // Only the high half of a surrogate pair leaves without run_last.
  a_high: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !run_last |-> !is_error && !string_done && code_unit[15:10] == 6'b110110)
    else $error("non-final beat is not a high surrogate");

  // Once a high surrogate is taken, the next beat shown is its low half.
  a_low: assert property (@(posedge clk) disable iff (rst)
    unit_valid && !unit_stall && !run_last ##1 unit_valid |->
      run_last && !is_error && code_unit[15:10] == 6'b110111)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_stream_decoder utd_checker u_utd_checker (
  .clk         (clk),
  .rst         (rst),
  .unit_valid  (unit_valid),
  .unit_stall  (unit_stall),
  .code_unit   (code_unit),
  .is_error    (is_error),
  .run_last    (run_last),
  .string_done (string_done)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import utd_pkg::*;

  // Clock and the single reset pulse at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Byte channel, driven by the sender tasks below.
  logic       byte_valid    = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte     = 8'd0;
  logic       end_of_string = 1'b0;

  // Unit channel; unit_stall is driven by the receiver process.
  logic        unit_valid;
  logic        unit_stall = 1'b0;
  logic [15:0] code_unit;
  logic        is_error;
  logic        run_last;
  logic        string_done;

  utf8_to_utf16_stream_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .end_of_string(end_of_string),
    .unit_valid   (unit_valid),
    .unit_stall   (unit_stall),
    .code_unit    (code_unit),
    .is_error     (is_error),
    .run_last     (run_last),
    .string_done  (string_done)
  );

  // One beat on the unit channel as the decoder should produce it.
  typedef struct packed {
    logic [15:0] unit;
    logic        err;
    logic        last;
    logic        done;
  } unit_beat_t;

  // UTF-16 beats predicted from accepted bytes, oldest first.
  unit_beat_t expected_units[$];

  // Decoder state as the predictor tracks it.
  logic [SCALAR_W-1:0] scalar_acc  = '0;
  logic [1:0]          owed_count  = 2'd0;
  logic                dropping    = 1'b0;

  // Percentages for idle cycles on each side, and a pending receiver hold-off.
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int bytes_sent = 0;
  int errors     = 0;

  function automatic void queue_beat(input logic [15:0] unit, input logic err,
                                     input logic last, input logic done);
    unit_beat_t b;
    b.unit = unit;
    b.err  = err;
    b.last = last;
    b.done = done;
    expected_units = {expected_units, b};
  endfunction

  // Any fault gives one error beat; the rest of the string is dropped unless
  // the faulting byte was itself the end byte.
  function automatic void report_fault(input logic eos);
    queue_beat(16'd0, 1'b1, 1'b1, eos);
    scalar_acc = '0;
    owed_count = 2'd0;
    dropping   = !eos;
  endfunction

  // Advances the predicted decoder by one accepted byte and queues the UTF-16
  // beats that this byte completes.
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic [SCALAR_W-1:0] offset;
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return;
    end
    if (owed_count == 2'd0) begin
      if (b <= ASCII_MAX) begin
        scalar_acc = {13'd0, b};
      end else if (b <= CONT_MAX) begin
        // A continuation byte where a lead byte belongs.
        report_fault(eos);
        return;
      end else if (b <= LEAD2_MAX) begin
        scalar_acc = {16'd0, b[4:0]};
        owed_count = 2'd1;
      end else if (b <= LEAD3_MAX) begin
        scalar_acc = {17'd0, b[3:0]};
        owed_count = 2'd2;
      end else if (b <= LEAD4_MAX) begin
        scalar_acc = {18'd0, b[2:0]};
        owed_count = 2'd3;
      end else begin
        // Lead bytes 0xF8 and up are never legal.
        report_fault(eos);
        return;
      end
    end else begin
      if (b < CONT_MIN || b > CONT_MAX) begin
        report_fault(eos);
        return;
      end
      scalar_acc = {scalar_acc[14:0], b[5:0]};
      owed_count = owed_count - 2'd1;
    end
    if (owed_count != 2'd0) begin
      // The end mark arrived in the middle of a sequence.
      if (eos) report_fault(eos);
      return;
    end
    if ((scalar_acc >= SURR_MIN && scalar_acc <= SURR_MAX) || scalar_acc > SCALAR_MAX) begin
      report_fault(eos);
      return;
    end
    if (scalar_acc <= BMP_MAX) begin
      queue_beat(scalar_acc[15:0], 1'b0, 1'b1, eos);
    end else begin
      // Above the basic plane: high surrogate first, then the low one, which
      // alone carries the end-of-run and end-of-string marks.
      offset = scalar_acc - PLANE1;
      queue_beat(HIGH_BASE + {6'd0, offset[19:10]}, 1'b0, 1'b0, 1'b0);
      queue_beat(LOW_BASE + {6'd0, offset[9:0]}, 1'b0, 1'b1, eos);
    end
    scalar_acc = '0;
  endfunction

  // Offers one byte, possibly after some idle cycles, and returns at the edge
  // where the beat is accepted. Valid is left high so that a following byte
  // can go out back to back; the next call or the drain task decides.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      byte_valid <= 1'b0;
      data_byte  <= 8'($urandom);
      @(posedge clk);
    end
    byte_valid    <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  // The sender goes quiet until every predicted beat has been seen.
  task automatic wait_for_results();
    byte_valid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  // Short hand-picked strings: the byte extremes, every sequence length, a
  // surrogate pair, an overlong form, and one string for each kind of fault.
  task automatic test_directed();
    send_byte(8'h00, 1'b0); send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // Stray continuation; the following bytes are dropped up to the end mark.
    send_byte(8'hBF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h41, 1'b1);
    // Bad lead byte that is also the end byte.
    send_byte(8'hFF, 1'b1);
    // Bad continuation on the end byte.
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b1);
    // Truncated sequence at the end mark.
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    // Encoded surrogate value.
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b1);
    // Largest four-byte pattern, far above the scalar range.
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // A lone ASCII string ending at its only byte.
    send_byte(8'h7F, 1'b1);
    wait_for_results();
  endtask

  // Random strings made mostly of well-formed sequences with random content,
  // mixed with truncated sequences and raw random bytes.
  task automatic test_random_strings(input int n_bytes);
    logic [7:0]          str[$];
    logic [7:0]          enc[4];
    logic [SCALAR_W-1:0] s;
    int                  target;
    int                  kind;
    int                  nb;
    int                  keep;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      str.delete();
      repeat ($urandom_range(6, 1)) begin
        kind = $urandom_range(99);
        if (kind < 15) begin
          str = {str, 8'($urandom)};
        end else begin
          nb = $urandom_range(4, 1);
          s  = SCALAR_W'($urandom);
          // Keep most four-byte scalars inside the legal range.
          if (nb == 4 && $urandom_range(3) != 0) s = SCALAR_W'($urandom_range(32'h10FFFF));
          case (nb)
            1: enc[0] = {1'b0, s[6:0]};
            2: begin
              enc[0] = {3'b110, s[10:6]};
              enc[1] = {2'b10, s[5:0]};
            end
            3: begin
              enc[0] = {4'b1110, s[15:12]};
              enc[1] = {2'b10, s[11:6]};
              enc[2] = {2'b10, s[5:0]};
            end
            default: begin
              enc[0] = {5'b11110, s[20:18]};
              enc[1] = {2'b10, s[17:12]};
              enc[2] = {2'b10, s[11:6]};
              enc[3] = {2'b10, s[5:0]};
            end
          endcase
          keep = (kind < 25 && nb > 1) ? $urandom_range(nb - 1, 1) : nb;
          for (int i = 0; i < keep; i++) str = {str, enc[i]};
        end
      end
      foreach (str[i]) send_byte(str[i], i == str.size() - 1);
    end
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while bytes keep coming at full
  // rate, so the internal queue fills and the byte channel has to stall.
  task automatic test_receiver_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 150;
    test_random_strings(60);
  endtask

  // Receiver: checks each accepted beat against the oldest prediction and
  // drives unit_stall for the next cycle. Both the checks and the stall
  // decision run at the rising edge, so they see pre-edge values.
  always @(posedge clk) begin : unit_receiver
    unit_beat_t want;
    if (!rst && unit_valid && !unit_stall) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unit beat with none expected, actual code_unit %h is_error %b",
                 $time, code_unit, is_error);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (code_unit !== want.unit) begin
          $display("%0t: code_unit expected %h actual %h", $time, want.unit, code_unit);
          errors++;
        end
        if (is_error !== want.err) begin
          $display("%0t: is_error expected %b actual %b", $time, want.err, is_error);
          errors++;
        end
        if (run_last !== want.last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.last, run_last);
          errors++;
        end
        if (string_done !== want.done) begin
          $display("%0t: string_done expected %b actual %b", $time, want.done, string_done);
          errors++;
        end
      end
    end
    // A requested hold-off is counted down here, one cycle per edge.
    if (hold_left > 0) begin
      unit_stall <= 1'b1;
      hold_left--;
    end else begin
      unit_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_receiver_holdoff();

    // Random phases: no idling, a slow sender, a slow receiver, then both.
    idle_pct = 0;  stall_pct = 0;  test_random_strings(150);
    idle_pct = 84; stall_pct = 0;  test_random_strings(150);
    idle_pct = 0;  stall_pct = 84; test_random_strings(150);
    idle_pct = 24; stall_pct = 24; test_random_strings(150);

    // Every beat has been matched; give any stray output time to show up.
    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/utd_pkg.sv
design/utd_front.sv
design/utd_queue.sv
design/utd_back.sv
design/utf8_to_utf16_stream_decoder.sv
design/utd_checker.sv
verif/tb.sv
